@@ rtl/msd_pkg.sv @@
// Shared types, constants and the Morse lookup table for the symbol decoder.
// No dependencies; every other file in rtl/ imports this package.
package msd_pkg;

    // Token limits and character constants.
    localparam int unsigned MAX_MARKS  = 6;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned SYM_W      = 8;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_UNDER = 7'h5F;
    localparam logic [CNT_W-1:0]  CNT_SAT    = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DOT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACEY = 3'd4;

    // One result word.
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              has_char;
        logic              error;
        logic              last;
    } t_result;

    // Token and string state carried between symbols.
    typedef struct packed {
        logic [MAX_MARKS-1:0] mark_bits;
        logic [CNT_W-1:0]     mark_count;
        logic                 token_bad;
        logic                 string_error;
    } t_token;

    // Configuration values seen by the step logic.
    typedef struct packed {
        logic [SYM_W-1:0] dot_code;
        logic [SYM_W-1:0] dash_code;
        logic [SYM_W-1:0] separator_code;
        logic [SYM_W-1:0] blank_code;
        logic             spacey_mode;
    } t_cfg;

    // Pattern lookup. Mark i sits at bit i, a one is a dash. Where two
    // characters share a pattern the higher code is the one listed.
    // Returns zero when the pattern is not in the table.
    function automatic logic [CHAR_W-1:0] lookup(input logic [MAX_MARKS-1:0] bits,
                                                 input logic [CNT_W-1:0] count);
        logic [CHAR_W-1:0] c;
        c = CHAR_NONE;
        case ({count, bits})
            {3'd2, 6'b000010}: c = 7'h61; // a
            {3'd4, 6'b000001}: c = 7'h62; // b
            {3'd4, 6'b000101}: c = 7'h63; // c
            {3'd3, 6'b000001}: c = 7'h64; // d
            {3'd1, 6'b000000}: c = 7'h65; // e
            {3'd4, 6'b000100}: c = 7'h66; // f
            {3'd3, 6'b000011}: c = 7'h67; // g
            {3'd4, 6'b000000}: c = 7'h68; // h
            {3'd2, 6'b000000}: c = 7'h69; // i
            {3'd4, 6'b001110}: c = 7'h6A; // j
            {3'd3, 6'b000101}: c = 7'h6B; // k
            {3'd4, 6'b000010}: c = 7'h6C; // l
            {3'd2, 6'b000011}: c = 7'h6D; // m
            {3'd2, 6'b000001}: c = 7'h6E; // n
            {3'd3, 6'b000111}: c = 7'h6F; // o
            {3'd4, 6'b000110}: c = 7'h70; // p
            {3'd4, 6'b001011}: c = 7'h71; // q
            {3'd3, 6'b000010}: c = 7'h72; // r
            {3'd3, 6'b000000}: c = 7'h73; // s
            {3'd1, 6'b000001}: c = 7'h74; // t
            {3'd3, 6'b000100}: c = 7'h75; // u
            {3'd4, 6'b001000}: c = 7'h76; // v
            {3'd3, 6'b000110}: c = 7'h77; // w
            {3'd4, 6'b001001}: c = 7'h78; // x
            {3'd4, 6'b001101}: c = 7'h79; // y
            {3'd4, 6'b000011}: c = 7'h7A; // z
            {3'd6, 6'b101010}: c = 7'h3F; // ? (shares with .)
            {3'd6, 6'b010101}: c = 7'h3B; // ;
            {3'd5, 6'b000011}: c = 7'h3A; // : (shares with 7)
            {3'd5, 6'b001111}: c = 7'h39; // 9
            {3'd5, 6'b000111}: c = 7'h38; // 8
            {3'd5, 6'b000001}: c = 7'h36; // 6
            {3'd5, 6'b000000}: c = 7'h35; // 5
            {3'd5, 6'b010000}: c = 7'h34; // 4
            {3'd5, 6'b011000}: c = 7'h33; // 3
            {3'd5, 6'b011100}: c = 7'h32; // 2
            {3'd5, 6'b011110}: c = 7'h31; // 1
            {3'd5, 6'b011111}: c = 7'h30; // 0
            {3'd5, 6'b001001}: c = 7'h2F; // /
            {3'd6, 6'b100001}: c = 7'h2D; // -
            {3'd6, 6'b110011}: c = 7'h2C; // ,
            default:           c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/morse_symbol_decoder_top.sv @@
// Top level of the Morse symbol decoder: input register, configuration
// registers, token state and result stage. Depends on msd_pkg, msd_step
// and msd_out_stage.
//
// Usage: each accepted symbol word goes into an input register, and the step
// logic decodes it against the token state and, once the result stage is free,
// loads zero, one or two result words into the result stage, which registers
// them and offers the first on the output. One symbol is taken per cycle as long
// as each produces at most one result and the sink is ready. A symbol that
// produces two results holds the result stage for two output handshakes, since
// that stage hands out one word per cycle while the sink is ready, so the next
// symbol waits until the first of them has left. Two results come from a
// separator at the end of a string, and in spacey mode from any other symbol at
// the end of a string. The configuration port always accepts; write it only
// while no symbol is in flight. Indexes above the register list are ignored.
module morse_symbol_decoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Symbol input channel.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [msd_pkg::SYM_W-1:0]         i_symbol,
    input  logic                              i_end_of_string,
    // Result output channel.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [msd_pkg::CHAR_W-1:0]        o_out_char,
    output logic                              o_has_char,
    output logic                              o_error,
    output logic                              o_last,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [msd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [msd_pkg::SYM_W-1:0]         i_cfg_data
);
    import msd_pkg::*;

    logic             r_in_valid;
    logic [SYM_W-1:0] r_symbol;
    logic             r_eos;
    t_cfg             r_cfg;
    t_token           r_token;
    t_token           step_token;
    t_result          step_res0;
    t_result          step_res1;
    logic [1:0]       step_count;
    logic             out_free;
    logic             advance;
    logic             in_take;

    // Handshake control: the held symbol moves on when the result stage frees.
    always_comb begin
        advance = r_in_valid && out_free;
        o_ready = !r_in_valid || advance;
        in_take = i_valid && o_ready;
    end

    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_symbol <= i_symbol;
            r_eos    <= i_end_of_string;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_code       <= 8'd46;
            r_cfg.dash_code      <= 8'd45;
            r_cfg.separator_code <= 8'd120;
            r_cfg.blank_code     <= 8'd32;
            r_cfg.spacey_mode    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DOT:    r_cfg.dot_code       <= i_cfg_data;
                CFG_DASH:   r_cfg.dash_code      <= i_cfg_data;
                CFG_SEP:    r_cfg.separator_code <= i_cfg_data;
                CFG_BLANK:  r_cfg.blank_code     <= i_cfg_data;
                CFG_SPACEY: r_cfg.spacey_mode    <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Token state updates as each symbol is decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= '0;
        end else if (advance) begin
            r_token <= step_token;
        end
    end

    msd_step u_step (
        .i_symbol        (r_symbol),
        .i_end_of_string (r_eos),
        .i_cfg           (r_cfg),
        .i_token         (r_token),
        .o_token         (step_token),
        .o_res0          (step_res0),
        .o_res1          (step_res1),
        .o_count         (step_count)
    );

    msd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_res0     (step_res0),
        .i_res1     (step_res1),
        .i_count    (step_count),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_out_char (o_out_char),
        .o_has_char (o_has_char),
        .o_error    (o_error),
        .o_last     (o_last),
        .o_free     (out_free)
    );

endmodule

@@ rtl/msd_step.sv @@
// Per-symbol step logic: classifies a symbol, updates the token state and
// forms up to two result words. Depends on msd_pkg.
module msd_step (
    input  logic [msd_pkg::SYM_W-1:0] i_symbol,
    input  logic                      i_end_of_string,
    input  msd_pkg::t_cfg             i_cfg,
    input  msd_pkg::t_token           i_token,
    output msd_pkg::t_token           o_token,
    output msd_pkg::t_result          o_res0,
    output msd_pkg::t_result          o_res1,
    output logic [1:0]                o_count
);
    import msd_pkg::*;

    logic                 is_sep;
    logic                 is_dot;
    logic                 is_dash;
    logic                 is_mark;
    logic                 is_other;
    logic                 err;
    logic [MAX_MARKS-1:0] upd_bits;
    logic [CNT_W-1:0]     upd_count;
    logic [MAX_MARKS-1:0] cls_bits;
    logic [CNT_W-1:0]     cls_count;
    logic                 cls_bad;
    logic [CHAR_W-1:0]    dec;
    logic [CHAR_W-1:0]    mapped;
    t_result              sep_res;
    t_result              end_res;
    t_result              space_res;

    // Symbol class: separator first, then dot, then dash, else blank/invalid.
    always_comb begin
        is_sep   = (i_symbol == i_cfg.separator_code);
        is_dot   = !is_sep && (i_symbol == i_cfg.dot_code);
        is_dash  = !is_sep && !is_dot && (i_symbol == i_cfg.dash_code);
        is_mark  = is_dot || is_dash;
        is_other = !is_sep && !is_mark;
        err      = i_token.string_error || (is_other && (i_symbol != i_cfg.blank_code));
    end

    // Token after a mark is appended; the count saturates past the limit.
    always_comb begin
        upd_bits  = i_token.mark_bits;
        upd_count = i_token.mark_count;
        if (i_token.mark_count < CNT_W'(MAX_MARKS)) begin
            if (is_dash) begin
                upd_bits[i_token.mark_count] = 1'b1;
            end
            upd_count = i_token.mark_count + 1'b1;
        end else begin
            upd_count = CNT_SAT;
        end
    end

    // A separator closes the current token; otherwise the end of the string
    // closes the token as updated by this symbol.
    always_comb begin
        cls_bits  = is_sep ? i_token.mark_bits  : upd_bits;
        cls_count = is_sep ? i_token.mark_count : upd_count;
        cls_bad   = is_sep ? i_token.token_bad  : (i_token.token_bad || is_other);
        dec       = cls_bad ? CHAR_NONE : lookup(cls_bits, cls_count);
        mapped    = (i_cfg.spacey_mode && ({1'b0, dec} == i_cfg.blank_code)) ?
                    CHAR_UNDER : dec;
    end

    // Candidate result words.
    always_comb begin
        sep_res.out_char   = (dec != CHAR_NONE) ? mapped : CHAR_SPACE;
        sep_res.has_char   = 1'b1;
        sep_res.error      = err;
        sep_res.last       = 1'b0;

        end_res.out_char   = (is_sep || dec == CHAR_NONE) ? CHAR_NONE : mapped;
        end_res.has_char   = !is_sep && (dec != CHAR_NONE);
        end_res.error      = err;
        end_res.last       = 1'b1;

        space_res.out_char = CHAR_SPACE;
        space_res.has_char = 1'b1;
        space_res.error    = err;
        space_res.last     = 1'b0;
    end

    // Result selection and count.
    always_comb begin
        o_res1 = end_res;
        if (is_sep) begin
            o_res0  = sep_res;
            o_count = i_end_of_string ? 2'd2 : 2'd1;
        end else if (i_cfg.spacey_mode) begin
            o_res0  = space_res;
            o_count = i_end_of_string ? 2'd2 : 2'd1;
        end else begin
            o_res0  = end_res;
            o_count = i_end_of_string ? 2'd1 : 2'd0;
        end
    end

    // Next token state; the end of the string returns everything to reset.
    always_comb begin
        o_token = i_token;
        if (i_end_of_string) begin
            o_token = '0;
        end else if (is_sep) begin
            o_token.mark_bits  = '0;
            o_token.mark_count = '0;
            o_token.token_bad  = 1'b0;
        end else if (is_mark) begin
            o_token.mark_bits  = upd_bits;
            o_token.mark_count = upd_count;
        end else begin
            o_token.token_bad    = 1'b1;
            o_token.string_error = err;
        end
    end

endmodule

@@ rtl/msd_out_stage.sv @@
// Result register pair: holds up to two result words from one symbol and
// hands them out one per handshake. Depends on msd_pkg.
module msd_out_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  msd_pkg::t_result              i_res0,
    input  msd_pkg::t_result              i_res1,
    input  logic [1:0]                    i_count,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [msd_pkg::CHAR_W-1:0]    o_out_char,
    output logic                          o_has_char,
    output logic                          o_error,
    output logic                          o_last,
    output logic                          o_free
);
    import msd_pkg::*;

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_result    r_res0;
    t_result    r_res1;
    logic       pop;

    // The stage can take new words once the last held word leaves.
    always_comb begin
        pop    = (r_count != 2'd0) && i_ready;
        o_free = (r_count == 2'd0) || ((r_count == 2'd1) && i_ready);
    end

    // Count of held words.
    always_comb begin
        n_count = r_count;
        if (i_load) begin
            n_count = i_count;
        end else if (pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Word storage: a pop with two held shifts the second word forward.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res0 <= i_res0;
            r_res1 <= i_res1;
        end else if (pop) begin
            r_res0 <= r_res1;
        end
    end

    assign o_valid    = (r_count != 2'd0);
    assign o_out_char = r_res0.out_char;
    assign o_has_char = r_res0.has_char;
    assign o_error    = r_res0.error;
    assign o_last     = r_res0.last;

endmodule
